// ===== rtl/core/sparse_row_matrix_store_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sparse row matrix store
// Shared forms of the concurrent checks; the including module provides
// clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef SPARSE_ROW_MATRIX_STORE_ASSERT_SVH
`define SPARSE_ROW_MATRIX_STORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRMS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/srms_pkg.sv =====
// ---------------------------------------------------------------------------
// srms_pkg
// Codes, register layout and default sizes of the sparse row matrix store.
// ---------------------------------------------------------------------------
package srms_pkg;

  // Default sizes
  localparam int DEF_ROWS         = 64;
  localparam int DEF_ROW_CAPACITY = 16;
  localparam int DEF_COL_BITS     = 16;
  localparam int DEF_VALUE_BITS   = 32;

  // Fixed field widths
  localparam int ROW_W  = 6;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd2;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd3;

  // Configuration port
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  localparam int ROWS_IN_USE_W = 7;
  localparam int COLS_IN_USE_W = 17;
  localparam logic [ROWS_IN_USE_W-1:0] ROWS_IN_USE_RST = 7'd64;
  localparam logic [COLS_IN_USE_W-1:0] COLS_IN_USE_RST = 17'd65536;

endpackage

// ===== rtl/core/sparse_row_matrix_store.sv =====
// Sequence: a range error goes from the row count fetch straight to the result; a lookup or
//   update runs a binary search over the row, and an insert then shifts the later slots up.
// Throughput: one item at a time; the next item is taken as soon as the result
//   sits in the output register.
// Reset: synchronous; a clearing pass zeroes every row count before the first
//   item is taken. Configuration writes are taken at any time.
// ---------------------------------------------------------------------------
// sparse_row_matrix_store
// Sparse matrix kept as rows of column-sorted entries in one entry memory,
// with a per-row count memory. Set, add (saturating) and get by binary search.
// ---------------------------------------------------------------------------
module sparse_row_matrix_store
  import srms_pkg::*;
#(
  parameter int ROWS         = DEF_ROWS,
  parameter int ROW_CAPACITY = DEF_ROW_CAPACITY,
  parameter int COL_BITS     = DEF_COL_BITS,
  parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [CMD_W-1:0]             in_command,
  input  logic [ROW_W-1:0]             in_row,
  input  logic [COL_BITS-1:0]          in_col,
  input  logic signed [VALUE_BITS-1:0] in_operand,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_element_value,
  output logic                         out_was_present,
  output logic [STAT_W-1:0]            out_status,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_AW-1:0]            paddr,
  input  logic [CFG_DW-1:0]            pwdata,
  output logic [CFG_DW-1:0]            prdata,
  output logic                         pready
);

  // -------------------------------------------------------------------------
  // Derived sizes
  // -------------------------------------------------------------------------
  localparam int ENTRIES   = ROWS * ROW_CAPACITY;
  localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W     = $clog2(ROW_CAPACITY + 1);
  localparam int ENT_W     = COL_BITS + VALUE_BITS;
  localparam int CMP_W     = (COL_BITS > COLS_IN_USE_W) ? COL_BITS : COLS_IN_USE_W;
  localparam int ROWCMP_W  = 32;

  localparam logic [CNT_W-1:0]     CAP_C      = CNT_W'(ROW_CAPACITY);
  localparam logic [ROW_IDX_W-1:0] LAST_ROW_C = ROW_IDX_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0]    CAP_A      = ADDR_W'(ROW_CAPACITY);
  localparam logic [VALUE_BITS-1:0] VAL_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN   = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // -------------------------------------------------------------------------
  // Sequencer states
  // -------------------------------------------------------------------------
  localparam logic [3:0] S_CLEAR  = 4'd0;  // zero the row counts after reset
  localparam logic [3:0] S_IDLE   = 4'd1;  // wait for an input transfer
  localparam logic [3:0] S_LOOKUP = 4'd2;  // row count arrives, set up search
  localparam logic [3:0] S_SRCH   = 4'd3;  // issue probe at the midpoint
  localparam logic [3:0] S_CMP    = 4'd4;  // narrow the search window
  localparam logic [3:0] S_PROBE  = 4'd5;  // check the found slot
  localparam logic [3:0] S_DECIDE = 4'd6;  // update in place, reject or insert
  localparam logic [3:0] S_SHIFT  = 4'd7;  // move later slots up by one
  localparam logic [3:0] S_FIN    = 4'd8;  // hand the result to the output

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  logic [3:0]                   state_r, state_nxt;
  logic [ROW_IDX_W-1:0]         clr_idx_r, clr_idx_nxt;
  logic [CMD_W-1:0]             cmd_r, cmd_nxt;
  logic [ROW_IDX_W-1:0]         row_idx_r, row_idx_nxt;
  logic [COL_BITS-1:0]          col_r, col_nxt;
  logic [VALUE_BITS-1:0]        opv_r, opv_nxt;
  logic                         err_r, err_nxt;
  logic [ADDR_W-1:0]            base_r, base_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [CNT_W-1:0]             lo_r, lo_nxt;
  logic [CNT_W-1:0]             hi_r, hi_nxt;
  logic [CNT_W-1:0]             mid_r, mid_nxt;
  logic [CNT_W-1:0]             m_r, m_nxt;
  logic [CNT_W-1:0]             wr_slot_r, wr_slot_nxt;
  logic                         sh_pend_r, sh_pend_nxt;
  logic                         present_r, present_nxt;
  logic [VALUE_BITS-1:0]        old_val_r, old_val_nxt;
  logic [VALUE_BITS-1:0]        res_val_r, res_val_nxt;
  logic                         res_pres_r, res_pres_nxt;
  logic [STAT_W-1:0]            res_stat_r, res_stat_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]        out_val_r, out_val_nxt;
  logic                         out_pres_r, out_pres_nxt;
  logic [STAT_W-1:0]            out_stat_r, out_stat_nxt;
  logic [ROWS_IN_USE_W-1:0]     rows_in_use_r, rows_in_use_nxt;
  logic [COLS_IN_USE_W-1:0]     cols_in_use_r, cols_in_use_nxt;

  // -------------------------------------------------------------------------
  // Memories: per-row counts and column-sorted {col, value} entries
  // -------------------------------------------------------------------------
  logic [CNT_W-1:0]     cnt_mem [ROWS];
  logic [ENT_W-1:0]     ent_mem [ENTRIES];

  logic                 cnt_re;
  logic [ROW_IDX_W-1:0] cnt_raddr;
  logic [CNT_W-1:0]     cnt_rdata_r;
  logic                 cnt_we;
  logic [ROW_IDX_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]     cnt_wdata;

  logic                 ent_re;
  logic [ADDR_W-1:0]    ent_raddr;
  logic [ENT_W-1:0]     ent_rdata_r;
  logic                 ent_we;
  logic [ADDR_W-1:0]    ent_waddr;
  logic [ENT_W-1:0]     ent_wdata;

  always_ff @(posedge clk) begin
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_re) begin
      ent_rdata_r <= ent_mem[ent_raddr];
    end
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
  end

  // Read data split
  logic [COL_BITS-1:0]   ent_col;
  logic [VALUE_BITS-1:0] ent_val;
  assign ent_col = ent_rdata_r[ENT_W-1 -: COL_BITS];
  assign ent_val = ent_rdata_r[VALUE_BITS-1:0];

  // -------------------------------------------------------------------------
  // Handshake and configuration port
  // -------------------------------------------------------------------------
  logic in_xfer;
  logic out_xfer;
  logic out_free;
  logic cfg_wr;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign out_valid         = out_valid_r;
  assign out_element_value = out_val_r;
  assign out_was_present   = out_pres_r;
  assign out_status        = out_stat_r;

  always_comb begin
    unique case (paddr[REG_IDX_BIT])
      REG_ROWS_IN_USE: prdata = CFG_DW'(rows_in_use_r);
      REG_COLS_IN_USE: prdata = CFG_DW'(cols_in_use_r);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    rows_in_use_nxt = rows_in_use_r;
    cols_in_use_nxt = cols_in_use_r;
    if (cfg_wr) begin
      unique case (paddr[REG_IDX_BIT])
        REG_ROWS_IN_USE: rows_in_use_nxt = pwdata[ROWS_IN_USE_W-1:0];
        REG_COLS_IN_USE: cols_in_use_nxt = pwdata[COLS_IN_USE_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Range check on the incoming item
  // -------------------------------------------------------------------------
  logic in_err;
  assign in_err = ({1'b0, in_row} >= rows_in_use_r)
               || (ROWCMP_W'(in_row) >= ROWCMP_W'(ROWS))
               || (CMP_W'(in_col) >= CMP_W'(cols_in_use_r));

  // -------------------------------------------------------------------------
  // Datapath helpers
  // -------------------------------------------------------------------------
  logic [CNT_W:0]        mid_sum;
  logic                  is_set;
  logic                  is_add;
  logic [VALUE_BITS:0]   sum_w;
  logic                  sum_ovf;
  logic [VALUE_BITS-1:0] sum_val;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign is_set  = (cmd_r == CMD_SET);
  assign is_add  = (cmd_r == CMD_ADD);

  // Saturating add: extend by one bit, clamp when the top two bits disagree.
  assign sum_w   = {old_val_r[VALUE_BITS-1], old_val_r} + {opv_r[VALUE_BITS-1], opv_r};
  assign sum_ovf = sum_w[VALUE_BITS] ^ sum_w[VALUE_BITS-1];
  assign sum_val = sum_ovf ? (sum_w[VALUE_BITS] ? VAL_MIN : VAL_MAX)
                           : sum_w[VALUE_BITS-1:0];

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    cmd_nxt      = cmd_r;
    row_idx_nxt  = row_idx_r;
    col_nxt      = col_r;
    opv_nxt      = opv_r;
    err_nxt      = err_r;
    base_nxt     = base_r;
    cnt_nxt      = cnt_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    m_nxt        = m_r;
    wr_slot_nxt  = wr_slot_r;
    sh_pend_nxt  = sh_pend_r;
    present_nxt  = present_r;
    old_val_nxt  = old_val_r;
    res_val_nxt  = res_val_r;
    res_pres_nxt = res_pres_r;
    res_stat_nxt = res_stat_r;

    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_val_nxt   = out_val_r;
    out_pres_nxt  = out_pres_r;
    out_stat_nxt  = out_stat_r;

    cnt_re    = 1'b0;
    cnt_raddr = ROW_IDX_W'(in_row);
    cnt_we    = 1'b0;
    cnt_waddr = row_idx_r;
    cnt_wdata = cnt_r + CNT_W'(1);

    ent_re    = 1'b0;
    ent_raddr = base_r + ADDR_W'(mid_r);
    ent_we    = 1'b0;
    ent_waddr = base_r + ADDR_W'(lo_r);
    ent_wdata = {col_r, opv_r};

    unique case (state_r)
      S_CLEAR: begin
        // Zero one row count per cycle.
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx_r;
        cnt_wdata   = '0;
        clr_idx_nxt = clr_idx_r + ROW_IDX_W'(1);
        if (clr_idx_r == LAST_ROW_C) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          // Capture the item and fetch its row count.
          cnt_re      = 1'b1;
          cmd_nxt     = in_command;
          row_idx_nxt = ROW_IDX_W'(in_row);
          col_nxt     = in_col;
          opv_nxt     = in_operand;
          err_nxt     = in_err;
          base_nxt    = ADDR_W'(ROW_IDX_W'(in_row)) * CAP_A;
          state_nxt   = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        if (err_r) begin
          res_val_nxt  = '0;
          res_pres_nxt = 1'b0;
          res_stat_nxt = ST_RANGE;
          state_nxt    = S_FIN;
        end else begin
          cnt_nxt   = (cnt_rdata_r > CAP_C) ? CAP_C : cnt_rdata_r;
          lo_nxt    = '0;
          hi_nxt    = (cnt_rdata_r > CAP_C) ? CAP_C : cnt_rdata_r;
          state_nxt = S_SRCH;
        end
      end

      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CNT_W:1];
          ent_re    = 1'b1;
          ent_raddr = base_r + ADDR_W'(mid_sum[CNT_W:1]);
          state_nxt = S_CMP;
        end else if (lo_r < cnt_r) begin
          // First slot with column >= col: fetch it to test for a hit.
          ent_re    = 1'b1;
          ent_raddr = base_r + ADDR_W'(lo_r);
          state_nxt = S_PROBE;
        end else begin
          present_nxt = 1'b0;
          old_val_nxt = '0;
          state_nxt   = S_DECIDE;
        end
      end

      S_CMP: begin
        if (ent_col < col_r) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end

      S_PROBE: begin
        present_nxt = (ent_col == col_r);
        old_val_nxt = (ent_col == col_r) ? ent_val : '0;
        state_nxt   = S_DECIDE;
      end

      S_DECIDE: begin
        res_pres_nxt = present_r;
        res_stat_nxt = ST_OK;
        state_nxt    = S_FIN;
        if (!(is_set || is_add) || (is_add && (opv_r == '0))) begin
          // Read only: get, the spare command, or add of zero.
          res_val_nxt = old_val_r;
        end else if (present_r) begin
          // Update in place.
          ent_we      = 1'b1;
          ent_wdata   = {col_r, is_set ? opv_r : sum_val};
          res_val_nxt = is_set ? opv_r : sum_val;
          if (is_add && sum_ovf) begin
            res_stat_nxt = ST_SAT;
          end
        end else if (cnt_r >= CAP_C) begin
          res_val_nxt  = '0;
          res_stat_nxt = ST_FULL;
        end else begin
          // Insert: open a gap at the found slot.
          res_val_nxt = opv_r;
          m_nxt       = cnt_r;
          sh_pend_nxt = 1'b0;
          state_nxt   = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // Read slot m-1 while writing the previous read into the slot above it.
        if (sh_pend_r) begin
          ent_we    = 1'b1;
          ent_waddr = base_r + ADDR_W'(wr_slot_r);
          ent_wdata = ent_rdata_r;
        end
        if (m_r > lo_r) begin
          ent_re      = 1'b1;
          ent_raddr   = base_r + ADDR_W'(m_r - CNT_W'(1));
          wr_slot_nxt = m_r;
          m_nxt       = m_r - CNT_W'(1);
          sh_pend_nxt = 1'b1;
        end else begin
          sh_pend_nxt = 1'b0;
          if (!sh_pend_r) begin
            // Gap is open: drop in the new entry and bump the count.
            ent_we    = 1'b1;
            ent_waddr = base_r + ADDR_W'(lo_r);
            ent_wdata = {col_r, opv_r};
            cnt_we    = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_pres_nxt  = res_pres_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // State update
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      out_valid_r   <= 1'b0;
      sh_pend_r     <= 1'b0;
      rows_in_use_r <= ROWS_IN_USE_RST;
      cols_in_use_r <= COLS_IN_USE_RST;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      out_valid_r   <= out_valid_nxt;
      sh_pend_r     <= sh_pend_nxt;
      rows_in_use_r <= rows_in_use_nxt;
      cols_in_use_r <= cols_in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    row_idx_r  <= row_idx_nxt;
    col_r      <= col_nxt;
    opv_r      <= opv_nxt;
    err_r      <= err_nxt;
    base_r     <= base_nxt;
    cnt_r      <= cnt_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    m_r        <= m_nxt;
    wr_slot_r  <= wr_slot_nxt;
    present_r  <= present_nxt;
    old_val_r  <= old_val_nxt;
    res_val_r  <= res_val_nxt;
    res_pres_r <= res_pres_nxt;
    res_stat_r <= res_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_pres_r <= out_pres_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
`include "sparse_row_matrix_store_assert.svh"

  `SRMS_ASSERT_NXT(a_xfer_to_lookup, in_xfer, state_r == S_LOOKUP, "transfer did not start lookup")
  `SRMS_ASSERT_IMP(a_count_bound, (state_r == S_LOOKUP) && !err_r, cnt_rdata_r <= CAP_C, "row count above capacity")
  `SRMS_ASSERT_IMP(a_search_window, (state_r == S_SRCH) || (state_r == S_CMP), (lo_r <= hi_r) && (hi_r <= cnt_r), "search window broken")
  `SRMS_ASSERT_IMP(a_shift_above_slot, (state_r == S_SHIFT) && sh_pend_r, wr_slot_r > lo_r, "shift overwrote the insert slot")
  `SRMS_ASSERT_IMP(a_range_result, out_valid_r && (out_stat_r == ST_RANGE), (out_val_r == '0) && !out_pres_r, "range error with payload")

endmodule

// ===== tb/sparse_row_matrix_store_test.sv =====
// ---------------------------------------------------------------------------
// sparse_row_matrix_store_test
// Self-checking bench for the sparse row matrix store. A scoreboard mirrors
// the per-row sorted entry lists and the range registers. It predicts the
// value, presence bit and status of every request and checks each reply in
// order. Stimulus is a short directed run followed by random phases under
// several register settings, with random gaps on the input channel and random stalls on the result channel.
// ---------------------------------------------------------------------------
module sparse_row_matrix_store_test;
  import srms_pkg::*;

  localparam int COL_W = DEF_COL_BITS;
  localparam int VAL_W = DEF_VALUE_BITS;
  localparam int NROWS = DEF_ROWS;
  localparam int CAP   = DEF_ROW_CAPACITY;

  // Command 3 has no name in the package; the block treats it as a get.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE      = 40;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  operand;
  } matrix_request_t;

  typedef struct packed {
    logic [VAL_W-1:0]  element_value;
    logic              was_present;
    logic [STAT_W-1:0] status;
  } matrix_reply_t;

  // -------------------------------------------------------------------------
  // Scoreboard: mirror of the row lists plus the queue of expected replies
  // -------------------------------------------------------------------------
  class sparse_matrix_mirror;
    logic [ROWS_IN_USE_W-1:0] rows_limit;
    logic [COLS_IN_USE_W-1:0] cols_limit;
    int unsigned              row_fill [NROWS];
    logic [COL_W-1:0]         slot_col [NROWS][CAP];
    logic [VAL_W-1:0]         slot_val [NROWS][CAP];
    matrix_reply_t            pending_replies [$];
    int unsigned              requests, replies, failures;
    int unsigned              status_seen [4];

    function new();
      rows_limit = ROWS_IN_USE_RST;
      cols_limit = COLS_IN_USE_RST;
      foreach (row_fill[r]) row_fill[r] = 0;
      requests = 0;
      replies  = 0;
      failures = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("ERROR: %s", what);
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction

    // Work out the reply to one accepted request and apply its update.
    function void take_request(matrix_request_t req);
      matrix_reply_t   rep;
      int unsigned     fill, k, m;
      logic [VAL_W:0]  wide;
      logic [VAL_W-1:0] cur;
      rep = '0;
      requests++;
      if (req.row >= rows_limit || req.col >= cols_limit) begin
        rep.status = ST_RANGE;
      end else begin
        fill = row_fill[req.row];
        // first slot whose column is not below the requested one
        k = 0;
        while (k < fill && slot_col[req.row][k] < req.col) k++;
        rep.was_present = (k < fill) && (slot_col[req.row][k] == req.col);
        cur = rep.was_present ? slot_val[req.row][k] : '0;
        if (req.command == CMD_SET || req.command == CMD_ADD) begin
          if (req.command == CMD_ADD && req.operand == '0) begin
            // adding zero leaves the row untouched, even an absent entry
            rep.element_value = cur;
          end else if (rep.was_present) begin
            if (req.command == CMD_SET) begin
              rep.element_value = req.operand;
            end else begin
              wide = {cur[VAL_W-1], cur} + {req.operand[VAL_W-1], req.operand};
              if (wide[VAL_W] != wide[VAL_W-1]) begin
                rep.status = ST_SAT;
                rep.element_value = wide[VAL_W] ? VMIN : VMAX;
              end else begin
                rep.element_value = wide[VAL_W-1:0];
              end
            end
            slot_val[req.row][k] = rep.element_value;
          end else if (fill >= CAP) begin
            rep.status = ST_FULL;
          end else begin
            // open a slot at k by moving the later entries up one place
            for (m = fill; m > k; m--) begin
              slot_col[req.row][m] = slot_col[req.row][m-1];
              slot_val[req.row][m] = slot_val[req.row][m-1];
            end
            slot_col[req.row][k] = req.col;
            slot_val[req.row][k] = req.operand;
            row_fill[req.row]    = fill + 1;
            rep.element_value    = req.operand;
          end
        end else begin
          rep.element_value = cur;
        end
      end
      status_seen[rep.status]++;
      pending_replies.push_back(rep);
    endfunction

    // Compare one accepted reply against the oldest expectation.
    function void check_reply(matrix_reply_t got);
      matrix_reply_t want;
      replies++;
      if (pending_replies.size() == 0) begin
        flag($sformatf("reply %0d arrived with nothing pending: value %h present %b status %0d",
                       replies, got.element_value, got.was_present, got.status));
        return;
      end
      want = pending_replies.pop_front();
      if (got.element_value !== want.element_value || got.was_present !== want.was_present ||
          got.status !== want.status)
        flag($sformatf("reply %0d: value %h (want %h) present %b (want %b) status %0d (want %0d)",
                       replies, got.element_value, want.element_value, got.was_present,
                       want.was_present, got.status, want.status));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value
  // -------------------------------------------------------------------------
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command = CMD_GET;
  logic [ROW_W-1:0]  in_row     = '0;
  logic [COL_W-1:0]  in_col     = '0;
  logic [VAL_W-1:0]  in_operand = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [VAL_W-1:0]  out_element_value;
  logic              out_was_present;
  logic [STAT_W-1:0] out_status;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr      = '0;
  logic [CFG_DW-1:0] pwdata     = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  sparse_matrix_mirror mirror;
  logic                quiet = 1'b0;   // set for stretches with no idling at all
  int unsigned         cycle_count = 0;
  int unsigned         settings_used = 0;

  sparse_row_matrix_store DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_operand        (in_operand),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_value (out_element_value),
    .out_was_present   (out_was_present),
    .out_status        (out_status),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies still pending",
               cycle_count, mirror.outstanding());
      $display("sparse_row_matrix_store: mismatch");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Monitors: sample both channels at the edge where a transfer happens
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      mirror.take_request('{command: in_command, row: in_row, col: in_col, operand: in_operand});
    if (rst_n && out_valid && !out_stall)
      mirror.check_reply('{element_value: out_element_value, was_present: out_was_present,
                           status: out_status});
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: alternate stall bursts and open windows.
  initial begin : result_stall
    int unsigned n;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  function automatic matrix_request_t make_req(logic [CMD_W-1:0] cmd, int unsigned row,
                                               int unsigned col, logic [VAL_W-1:0] opnd);
    matrix_request_t req;
    req.command = cmd;
    req.row     = ROW_W'(row);
    req.col     = COL_W'(col);
    req.operand = opnd;
    return req;
  endfunction

  // Present one request and hold it until the transfer. Valid stays high on
  // return so a back-to-back request does not drop it for a cycle.
  task automatic send_request(input matrix_request_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= req.command;
    in_row     <= req.row;
    in_col     <= req.col;
    in_operand <= req.operand;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every expected reply. Wait for an edge first so the
  // monitor has recorded the last input transfer before the count is read.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.outstanding() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic idx, input logic wr, input logic [CFG_DW-1:0] data,
                            output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_AW'(idx) << REG_IDX_BIT;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write both range registers, update the mirror, and read them back.
  task automatic set_limits(input int unsigned rows, input int unsigned cols);
    logic [CFG_DW-1:0] rd;
    cfg_access(REG_ROWS_IN_USE, 1'b1, CFG_DW'(rows), rd);
    mirror.rows_limit = ROWS_IN_USE_W'(rows);
    cfg_access(REG_COLS_IN_USE, 1'b1, CFG_DW'(cols), rd);
    mirror.cols_limit = COLS_IN_USE_W'(cols);
    cfg_access(REG_ROWS_IN_USE, 1'b0, '0, rd);
    if (rd[ROWS_IN_USE_W-1:0] !== mirror.rows_limit)
      mirror.flag($sformatf("rows_in_use reads %h, wrote %h", rd, mirror.rows_limit));
    cfg_access(REG_COLS_IN_USE, 1'b0, '0, rd);
    if (rd[COLS_IN_USE_W-1:0] !== mirror.cols_limit)
      mirror.flag($sformatf("cols_in_use reads %h, wrote %h", rd, mirror.cols_limit));
    settings_used++;
  endtask

  function automatic logic [VAL_W-1:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 16) return VMAX;
    if (r < 22) return VMIN;
    if (r < 50) return VAL_W'($urandom_range(0, 2000)) - VAL_W'(1000);
    return VAL_W'($urandom);
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_SET;
    if (r < 70) return CMD_ADD;
    if (r < 95) return CMD_GET;
    return CMD_SPARE;
  endfunction

  // One random phase. Most requests hit a few hot rows with columns from a
  // small pool, so rows fill, entries get updated and full rows turn inserts
  // away; the rest are scattered over the whole row and column space.
  task automatic run_phase(input int unsigned rows, input int unsigned cols,
                           input int unsigned count, input logic calm);
    int unsigned     col_pool [20];
    int unsigned     hot_rows [3];
    int unsigned     row_top, col_top, i;
    matrix_request_t req;
    set_limits(rows, cols);
    quiet   = calm;
    row_top = (rows == 0) ? NROWS - 1 : ((rows < NROWS) ? rows - 1 : NROWS - 1);
    col_top = (cols == 0) ? 65535 : ((cols < 65536) ? cols - 1 : 65535);
    foreach (hot_rows[h]) hot_rows[h] = $urandom_range(0, row_top);
    foreach (col_pool[c]) col_pool[c] = $urandom_range(0, col_top);
    // keep the column range edges in the pool
    col_pool[0] = 0;
    col_pool[1] = col_top;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85)
        req = make_req(pick_command(), hot_rows[$urandom_range(0, 2)],
                       col_pool[$urandom_range(0, 19)], pick_operand());
      else
        req = make_req(pick_command(), $urandom_range(0, NROWS - 1),
                       $urandom_range(0, 65535), pick_operand());
      send_request(req);
    end
    drain();
    quiet = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main
    int unsigned i;
    mirror = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed run under the reset limits: saturation both ways, inserts in
    // front of and behind existing entries, add of zero on present and absent
    // entries, the spare command, the row and column extremes, and a row
    // filled until it turns an insert away.
    send_request(make_req(CMD_GET, 0, 0, VMAX));
    send_request(make_req(CMD_SET, 0, 100, VMAX));
    send_request(make_req(CMD_ADD, 0, 100, 1));
    send_request(make_req(CMD_SET, 0, 50, VMIN));
    send_request(make_req(CMD_ADD, 0, 50, '1));
    send_request(make_req(CMD_ADD, 0, 100, '0));
    send_request(make_req(CMD_ADD, 0, 7, '0));
    send_request(make_req(CMD_SET, 0, 65535, 32'h1234_5678));
    send_request(make_req(CMD_ADD, 0, 200, 32'h0001_8000));
    send_request(make_req(CMD_SPARE, 0, 50, '0));
    send_request(make_req(CMD_SET, 63, 0, '1));
    send_request(make_req(CMD_ADD, 63, 0, VMIN + 1));   // lands exactly on the minimum
    // fill row 0 from the low end so every insert shifts the whole row
    for (i = 12; i >= 1; i--)
      send_request(make_req(CMD_SET, 0, i, VAL_W'($urandom)));
    send_request(make_req(CMD_SET, 0, 13, 32'h0000_0001));
    send_request(make_req(CMD_ADD, 0, 14, '0));
    send_request(make_req(CMD_ADD, 0, 100, -32'sd5));
    drain();

    // Random phases over the register extremes and a random setting.
    run_phase(64, 65536, 400, 1'b0);
    run_phase(1, 1, 60, 1'b0);
    run_phase(127, 131071, 300, 1'b0);
    run_phase(0, 65536, 40, 1'b0);
    run_phase(64, 0, 40, 1'b0);
    run_phase($urandom_range(1, 64), $urandom_range(1, 65536), 300, 1'b1);
    run_phase(64, 65536, 360, 1'b0);

    // Let any stray reply show up before the verdict.
    repeat (SETTLE) @(posedge clk);
    if (mirror.outstanding() != 0)
      mirror.flag($sformatf("%0d replies never arrived", mirror.outstanding()));

    $display("Covered %0d requests and %0d replies over %0d register settings.",
             mirror.requests, mirror.replies, settings_used);
    $display("Status seen: ok %0d, row full %0d, out of range %0d, saturated %0d; %0d errors.",
             mirror.status_seen[ST_OK], mirror.status_seen[ST_FULL],
             mirror.status_seen[ST_RANGE], mirror.status_seen[ST_SAT], mirror.failures);
    if (mirror.failures == 0) begin
      $display("sparse_row_matrix_store: match");
    end else begin
      $display("sparse_row_matrix_store: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/srms_pkg.sv
rtl/core/sparse_row_matrix_store.sv
tb/sparse_row_matrix_store_test.sv
